// File: rtl/fbnr_pkg.sv
// ----------------------------------------------------------------------------
// fbnr_pkg: shared types for the framebuffer number renderer
// Command codes, controller/datapath handshake structs and the 4x5 font
// ----------------------------------------------------------------------------
package fbnr_pkg;

  localparam int InWidth   = 72;
  localparam int OutWidth  = 24;
  localparam int MaxDigits = 10;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_OR    = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_CONV,
    ST_DSEL,
    ST_COL,
    ST_LO,
    ST_HI,
    ST_CLR,
    ST_MRD,
    ST_MUPD,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic dsel;
    logic gap;
    logic col_next;
    logic lo_wr;
    logic hi_wr;
    logic clr;
    logic upd;
    logic out_load;
    logic init_wr;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic err;
    logic conv_last;
    logic digit_skip;
    logic col_end;
    logic last_digit;
    logic spill_en;
    logic clr_end;
    logic init_last;
    logic out_free;
  } dp_status_t;

  // 4x5 font, five bits per glyph column, bit 0 is the top row
  function automatic logic [4:0] glyph_col(input logic [3:0] d, input logic [1:0] c);
    logic [4:0] g;
    g = 5'h00;
    case ({d, c})
      {4'd0, 2'd0}: g = 5'h0e;
      {4'd0, 2'd1}: g = 5'h11;
      {4'd0, 2'd2}: g = 5'h11;
      {4'd0, 2'd3}: g = 5'h0e;
      {4'd1, 2'd0}: g = 5'h12;
      {4'd1, 2'd1}: g = 5'h1f;
      {4'd1, 2'd2}: g = 5'h10;
      {4'd1, 2'd3}: g = 5'h00;
      {4'd2, 2'd0}: g = 5'h12;
      {4'd2, 2'd1}: g = 5'h19;
      {4'd2, 2'd2}: g = 5'h15;
      {4'd2, 2'd3}: g = 5'h12;
      {4'd3, 2'd0}: g = 5'h0a;
      {4'd3, 2'd1}: g = 5'h11;
      {4'd3, 2'd2}: g = 5'h15;
      {4'd3, 2'd3}: g = 5'h0a;
      {4'd4, 2'd0}: g = 5'h0c;
      {4'd4, 2'd1}: g = 5'h0a;
      {4'd4, 2'd2}: g = 5'h1f;
      {4'd4, 2'd3}: g = 5'h08;
      {4'd5, 2'd0}: g = 5'h17;
      {4'd5, 2'd1}: g = 5'h15;
      {4'd5, 2'd2}: g = 5'h15;
      {4'd5, 2'd3}: g = 5'h09;
      {4'd6, 2'd0}: g = 5'h0e;
      {4'd6, 2'd1}: g = 5'h15;
      {4'd6, 2'd2}: g = 5'h15;
      {4'd6, 2'd3}: g = 5'h08;
      {4'd7, 2'd0}: g = 5'h01;
      {4'd7, 2'd1}: g = 5'h01;
      {4'd7, 2'd2}: g = 5'h19;
      {4'd7, 2'd3}: g = 5'h06;
      {4'd8, 2'd0}: g = 5'h0a;
      {4'd8, 2'd1}: g = 5'h15;
      {4'd8, 2'd2}: g = 5'h15;
      {4'd8, 2'd3}: g = 5'h0a;
      {4'd9, 2'd0}: g = 5'h02;
      {4'd9, 2'd1}: g = 5'h05;
      {4'd9, 2'd2}: g = 5'h15;
      {4'd9, 2'd3}: g = 5'h0e;
      default:      g = 5'h00;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/fbnr_ctrl.sv
// ----------------------------------------------------------------------------
// fbnr_ctrl: sequencing state machine
// Walks the clearing pass, dispatch, clear run, OR/read, conversion and draw loop
// ----------------------------------------------------------------------------
module fbnr_ctrl
  import fbnr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (st_i.init_last) state_d = ST_IDLE;
      ST_IDLE: if (s_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        if (st_i.cmd == CMD_DRAW) begin
          state_d = ST_CONV;
        end else if (st_i.err) begin
          state_d = ST_DONE;
        end else begin
          unique case (st_i.cmd) inside
            CMD_OR, CMD_READ: state_d = ST_MRD;
            default:          state_d = ST_CLR;
          endcase
        end
      end
      ST_CONV: if (st_i.conv_last) state_d = ST_DSEL;
      ST_DSEL: if (!st_i.digit_skip) state_d = ST_COL;
      ST_COL: begin
        if (st_i.col_end) begin
          state_d = st_i.last_digit ? ST_DONE : ST_DSEL;
        end else begin
          state_d = ST_LO;
        end
      end
      ST_LO:   state_d = st_i.spill_en ? ST_HI : ST_COL;
      ST_HI:   state_d = ST_COL;
      ST_CLR:  if (st_i.clr_end) state_d = ST_DONE;
      ST_MRD:  state_d = ST_MUPD;
      ST_MUPD: state_d = ST_DONE;
      ST_DONE: if (st_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: cmd_o.init_wr = 1'b1;
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_CONV: cmd_o.conv = 1'b1;
      ST_DSEL: cmd_o.dsel = 1'b1;
      ST_COL:  cmd_o.gap = st_i.col_end;
      ST_LO: begin
        cmd_o.lo_wr    = 1'b1;
        cmd_o.col_next = !st_i.spill_en;
      end
      ST_HI: begin
        cmd_o.hi_wr    = 1'b1;
        cmd_o.col_next = 1'b1;
      end
      ST_CLR:  cmd_o.clr = 1'b1;
      ST_MUPD: cmd_o.upd = 1'b1;
      ST_DONE: cmd_o.out_load = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/fbnr_datapath.sv
// ----------------------------------------------------------------------------
// fbnr_datapath: framebuffer memory, bcd converter and draw registers
// Executes controller commands and reports status back
// ----------------------------------------------------------------------------
module fbnr_datapath
  import fbnr_pkg::*;
#(
  parameter int PAGES   = 6,
  parameter int COLUMNS = 84
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  input  logic [InWidth-1:0]   in_data_i,
  input  logic                 m_ready_i,
  output dp_status_t           st_o,
  output logic                 m_valid_o,
  output logic [OutWidth-1:0]  m_data_o
);

  localparam int Depth = PAGES * COLUMNS;
  localparam int AW    = $clog2(Depth);

  // add-3 correction on every bcd digit before the shift
  function automatic logic [39:0] bcd_adj(input logic [39:0] v);
    logic [39:0] r;
    r = v;
    for (int i = 0; i < MaxDigits; i++) begin
      if (v[i*4 +: 4] >= 4'd5) r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
    end
    return r;
  endfunction

  logic [7:0] mem [Depth];

  cmd_e          cmd_q;
  logic [31:0]   num_q;
  logic [7:0]    x_q;
  logic [2:0]    page_q;
  logic [2:0]    shift_q;
  logic [7:0]    data_q;
  logic [6:0]    rem_q;
  logic          err_q, page_ok_q, spill_ok_q;
  logic [39:0]   bcd_q;
  logic [39:0]   bcd_next;
  logic [4:0]    bit_q;
  logic [3:0]    k_q;
  logic          seen_q;
  logic [3:0]    d_q;
  logic [2:0]    c_q;
  logic [7:0]    rd_q;
  logic [7:0]    rdata_q;
  logic [AW-1:0] init_q;
  logic          out_valid_q;
  logic [OutWidth-1:0] out_data_q;

  // input fields
  logic [1:0] in_cmd;
  logic [2:0] in_page;
  logic [5:0] in_y;
  assign in_cmd  = in_data_i[1:0];
  assign in_y    = in_data_i[46:41];
  assign in_page = (cmd_e'(in_cmd) == CMD_DRAW) ? in_y[5:3] : in_data_i[49:47];

  logic [3:0]  digit;
  logic [2:0]  width;
  logic        col_ok, col_end, clr_end, digit_skip;
  logic [4:0]  glyph;
  logic [11:0] shifted;
  logic [2:0]  page_hi;
  logic [10:0] addr_lo_w, addr_hi_w;
  logic [AW-1:0] addr_lo, addr_hi;

  assign bcd_next   = bcd_adj(bcd_q);
  assign digit      = bcd_q[6'(k_q) * 6'd4 +: 4];
  assign digit_skip = (digit == 4'd0) && !seen_q && (k_q != 4'd0);
  assign width      = (d_q == 4'd1) ? 3'd3 : 3'd4;
  assign col_ok     = x_q < 8'(COLUMNS);
  assign col_end    = (c_q == width) || !col_ok;
  assign clr_end    = (rem_q == 7'd0) || !col_ok;
  assign glyph      = glyph_col(d_q, c_q[1:0]);
  assign shifted    = 12'(glyph) << shift_q;
  assign page_hi    = page_q + 3'd1;
  assign addr_lo_w  = 11'(page_q) * 11'(COLUMNS) + 11'(x_q);
  assign addr_hi_w  = 11'(page_hi) * 11'(COLUMNS) + 11'(x_q);
  assign addr_lo    = addr_lo_w[AW-1:0];
  assign addr_hi    = addr_hi_w[AW-1:0];

  // memory port selection
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  always_comb begin
    we    = 1'b0;
    waddr = addr_lo;
    raddr = addr_lo;
    wdata = 8'h00;
    if (cmd_i.init_wr) begin
      we    = 1'b1;
      waddr = init_q;
    end
    if (cmd_i.lo_wr) begin
      raddr = addr_hi;
      we    = page_ok_q;
      wdata = rdata_q | shifted[7:0];
    end
    if (cmd_i.hi_wr) begin
      we    = 1'b1;
      waddr = addr_hi;
      wdata = rdata_q | {4'h0, shifted[11:8]};
    end
    if (cmd_i.clr) begin
      we = !clr_end;
    end
    if (cmd_i.upd && (cmd_q == CMD_OR)) begin
      we    = col_ok;
      wdata = rdata_q | data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_wr) init_q <= init_q + AW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_e'(in_cmd);
      num_q      <= in_data_i[33:2];
      x_q        <= {1'b0, in_data_i[40:34]};
      page_q     <= in_page;
      shift_q    <= in_y[2:0];
      data_q     <= in_data_i[57:50];
      rem_q      <= in_data_i[64:58];
      page_ok_q  <= {1'b0, in_page} < 4'(PAGES);
      spill_ok_q <= ({1'b0, in_page} + 4'd1) < 4'(PAGES);
      err_q      <= !({1'b0, in_page} < 4'(PAGES));
      bcd_q      <= '0;
      bit_q      <= '0;
      k_q        <= 4'(MaxDigits - 1);
      seen_q     <= 1'b0;
      rd_q       <= 8'h00;
    end
    if (cmd_i.conv) begin
      bcd_q <= {bcd_next[38:0], num_q[31]};
      num_q <= {num_q[30:0], 1'b0};
      bit_q <= bit_q + 5'd1;
    end
    if (cmd_i.dsel) begin
      if (digit_skip) begin
        k_q <= k_q - 4'd1;
      end else begin
        d_q    <= digit;
        c_q    <= 3'd0;
        seen_q <= 1'b1;
      end
    end
    if (cmd_i.col_next) begin
      x_q <= x_q + 8'd1;
      c_q <= c_q + 3'd1;
    end
    // gap column after each digit
    if (cmd_i.gap) begin
      x_q <= x_q + 8'd1;
      if (k_q != 4'd0) k_q <= k_q - 4'd1;
    end
    if (cmd_i.clr && !clr_end) begin
      x_q   <= x_q + 8'd1;
      rem_q <= rem_q - 7'd1;
    end
    if (cmd_i.upd && (cmd_q == CMD_READ)) begin
      rd_q <= col_ok ? rdata_q : 8'h00;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {7'b0, err_q, rd_q, (cmd_q == CMD_DRAW) ? x_q : 8'h00};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  always_comb begin
    st_o            = '0;
    st_o.cmd        = cmd_q;
    st_o.err        = err_q;
    st_o.conv_last  = bit_q == 5'd31;
    st_o.digit_skip = digit_skip;
    st_o.col_end    = col_end;
    st_o.last_digit = k_q == 4'd0;
    st_o.spill_en   = page_ok_q && spill_ok_q;
    st_o.clr_end    = clr_end;
    st_o.init_last  = init_q == AW'(Depth - 1);
    st_o.out_free   = !out_valid_q || m_ready_i;
  end

endmodule

// File: rtl/framebuffer_number_renderer_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_number_renderer_unit: page framebuffer with decimal renderer
// Draws numbers from a 4x5 font and serves byte OR, clear and read commands
// ----------------------------------------------------------------------------
// One command enters per transaction on s_axis and produces exactly one
// result transaction on m_axis. Commands are handled one at a time.
// After reset the block clears its PAGES*COLUMNS byte store, one byte per
// cycle, with s_axis_tready held low. Steps per command, accept to result:
//   OR byte / read byte: dispatch, memory read, update; page error: dispatch
//   clear run: dispatch, then run_count bytes in turn, clipped at the page end
//   draw: the 32 step binary to bcd shift loop, then per digit a select step
//         (leading zero digits stop there), per drawn column a read, a low-page
//         write and, when the next page exists, a high-page
//         write, and a closing gap column
// Draw time is set by the memory read-modify-write and the shift loop.
// The result sits in an output register; a new command is accepted while
// it waits. When m_axis_tready stays low the finished second result is
// held inside the block and s_axis_tready drops until the register frees.
// ----------------------------------------------------------------------------
module framebuffer_number_renderer_unit
  import fbnr_pkg::*;
#(
  parameter int PAGES   = 6,
  parameter int COLUMNS = 84
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd[1:0] number[33:2] pos_x[40:34] pos_y[46:41] page_index[49:47]
  // data_byte[57:50] run_count[64:58] zero[71:65]
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // next_x[7:0] read_data[15:8] range_error[16] zero[23:17]
  output logic [OutWidth-1:0] m_axis_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  fbnr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  fbnr_datapath #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .m_ready_i (m_axis_tready),
    .st_o      (st),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata)
  );

  // no command is taken during the clearing pass
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init_wr |-> !s_axis_tready)
    else $error("command accepted during clearing pass");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a command while busy");

  // a page error never returns read data
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:8] == 8'h00))
    else $error("read data on range error");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

endmodule

// File: tb/framebuffer_number_renderer_unit_tb.sv
// ----------------------------------------------------------------------------
// framebuffer_number_renderer_unit_tb: self-checking bench for the renderer
// Walks a short table of commands, then random draw, OR, clear and read
// traffic under several handshake phases. A local framebuffer image predicts
// every result not preset; results are matched in order to the expected queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framebuffer_number_renderer_unit_tb;
  import fbnr_pkg::*;

  localparam int PAGES            = 6;
  localparam int COLUMNS          = 84;
  localparam int STORE_BYTES      = PAGES * COLUMNS;
  localparam int ITEMS_PER_PHASE  = 375;
  localparam int NUM_PHASES       = 4;
  localparam int STALL_LIMIT      = 5000;
  localparam int DRAIN_CYCLES     = 400;
  localparam int NUM_DIRECTED     = 26;

  localparam int SRC_IDLE_PCT[NUM_PHASES]   = '{0, 74, 0, 24};
  localparam int SINK_STALL_PCT[NUM_PHASES] = '{0, 0, 74, 24};

  // glyph columns, bit 0 is the top pixel row
  localparam logic [0:9][0:3][7:0] FONT_COLS = {
    8'h0e, 8'h11, 8'h11, 8'h0e,
    8'h12, 8'h1f, 8'h10, 8'h00,
    8'h12, 8'h19, 8'h15, 8'h12,
    8'h0a, 8'h11, 8'h15, 8'h0a,
    8'h0c, 8'h0a, 8'h1f, 8'h08,
    8'h17, 8'h15, 8'h15, 8'h09,
    8'h0e, 8'h15, 8'h15, 8'h08,
    8'h01, 8'h01, 8'h19, 8'h06,
    8'h0a, 8'h15, 8'h15, 8'h0a,
    8'h02, 8'h05, 8'h15, 8'h0e
  };

  typedef struct packed {
    logic [6:0]  pad;
    logic [6:0]  run_count;
    logic [7:0]  data_byte;
    logic [2:0]  page_index;
    logic [5:0]  pos_y;
    logic [6:0]  pos_x;
    logic [31:0] number;
    cmd_e        cmd;
  } fb_cmd_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       range_error;
    logic [7:0] read_data;
    logic [7:0] next_x;
  } fb_result_t;

  typedef struct packed {
    logic       preset;
    fb_result_t res;
  } preset_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] number;
    logic [6:0]  pos_x;
    logic [5:0]  pos_y;
    logic [2:0]  page_index;
    logic [7:0]  data_byte;
    logic [6:0]  run_count;
    logic        preset;
    logic [7:0]  exp_next_x;
    logic [7:0]  exp_read;
    logic        exp_err;
  } dir_row_t;

  // cmd, number, x, y, page, data, run, preset, next_x, read, err
  localparam dir_row_t DIRECTED[NUM_DIRECTED] = '{
    '{CMD_READ,  0,          0,   0,  0, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          83,  0,  5, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          0,   0,  7, 8'h00, 0,   1, 0, 8'h00, 1},
    '{CMD_OR,    0,          10,  0,  6, 8'hff, 0,   1, 0, 8'h00, 1},
    '{CMD_CLEAR, 0,          0,   0,  7, 8'h00, 127, 1, 0, 8'h00, 1},
    '{CMD_OR,    0,          0,   0,  0, 8'hff, 0,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          0,   0,  0, 8'h00, 0,   1, 0, 8'hff, 0},
    '{CMD_OR,    0,          100, 0,  0, 8'haa, 0,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          127, 0,  0, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_CLEAR, 0,          0,   0,  0, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          0,   0,  0, 8'h00, 0,   1, 0, 8'hff, 0},
    '{CMD_CLEAR, 0,          0,   0,  0, 8'h00, 1,   1, 0, 8'h00, 0},
    '{CMD_READ,  0,          0,   0,  0, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_DRAW,  0,          0,   0,  0, 8'h00, 0,   1, 5, 8'h00, 0},
    '{CMD_READ,  0,          0,   0,  0, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_DRAW,  4294967295, 0,   11, 0, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_READ,  0,          1,   0,  1, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_READ,  0,          1,   0,  2, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_DRAW,  1111111111, 80,  47, 0, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_READ,  0,          83,  0,  5, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_DRAW,  1234567890, 20,  56, 0, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_DRAW,  1286608618, 127, 63, 7, 8'hff, 127, 0, 0, 8'h00, 0},
    '{CMD_CLEAR, 0,          60,  0,  1, 8'h00, 127, 1, 0, 8'h00, 0},
    '{CMD_READ,  0,          83,  0,  1, 8'h00, 0,   1, 0, 8'h00, 0},
    '{CMD_DRAW,  10,         84,  40, 0, 8'h00, 0,   0, 0, 8'h00, 0},
    '{CMD_OR,    0,          83,  0,  5, 8'h80, 0,   1, 0, 8'h00, 0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // cmd number pos_x pos_y page_index data_byte run_count zero-fill
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // next_x read_data range_error zero-fill
  logic [OutWidth-1:0] m_axis_tdata;

  framebuffer_number_renderer_unit #(
    .PAGES  (PAGES),
    .COLUMNS(COLUMNS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  logic [7:0] frame_image [STORE_BYTES];
  fb_result_t pending_results[$];
  preset_t    preset_q[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int quiet_cycles;
  int result_count;
  int draw_count, or_count, clear_count, read_count, range_err_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // renders value into the image, returns the column after the last gap
  function automatic logic [7:0] render_number(input logic [31:0] value, input int x_start,
                                               input int row, output logic bad_page);
    logic [3:0]  digs [10];
    logic [31:0] rest;
    logic [15:0] bits;
    logic        page_ok;
    logic        spill_ok;
    int          count, page, shift, x, k, c, width;
    page     = row / 8;
    shift    = row % 8;
    page_ok  = page < PAGES;
    spill_ok = (page + 1) < PAGES;
    bad_page = !page_ok;
    rest     = value;
    count    = 0;
    do begin
      digs[count] = 4'(rest % 10);
      count++;
      rest = rest / 10;
    end while (rest != 0 && count < 10);
    x = x_start;
    for (k = count - 1; k >= 0; k--) begin
      width = (digs[k] == 4'd1) ? 3 : 4;
      for (c = 0; c < width; c++) begin
        // clipped column ends the digit, its gap still counts
        if (x >= COLUMNS) break;
        bits = 16'(FONT_COLS[digs[k]][c]) << shift;
        if (page_ok) begin
          frame_image[page * COLUMNS + x] |= bits[7:0];
          if (spill_ok) frame_image[(page + 1) * COLUMNS + x] |= bits[15:8];
        end
        x++;
      end
      x++;
    end
    return 8'(x);
  endfunction

  function automatic fb_result_t predict_result(input fb_cmd_t c);
    fb_result_t r;
    logic       bad;
    int         base, i, col;
    r = '0;
    if (c.cmd == CMD_DRAW) begin
      r.next_x      = render_number(c.number, c.pos_x, c.pos_y, bad);
      r.range_error = bad;
    end else if (c.page_index >= PAGES) begin
      r.range_error = 1'b1;
    end else begin
      base = c.page_index * COLUMNS;
      case (c.cmd)
        CMD_OR: begin
          if (c.pos_x < COLUMNS) frame_image[base + c.pos_x] |= c.data_byte;
        end
        CMD_CLEAR: begin
          for (i = 0; i < c.run_count; i++) begin
            col = c.pos_x + i;
            if (col >= COLUMNS) break;
            frame_image[base + col] = 8'h00;
          end
        end
        default: begin
          if (c.pos_x < COLUMNS) r.read_data = frame_image[base + c.pos_x];
        end
      endcase
    end
    return r;
  endfunction

  function automatic fb_cmd_t random_command();
    fb_cmd_t c;
    int      pick;
    c    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35)      c.cmd = CMD_DRAW;
    else if (pick < 55) c.cmd = CMD_OR;
    else if (pick < 68) c.cmd = CMD_CLEAR;
    else                c.cmd = CMD_READ;
    case ($urandom_range(0, 3))
      0:       c.number = $urandom;
      1:       c.number = $urandom_range(0, 999);
      2:       c.number = $urandom >> $urandom_range(0, 31);
      default: c.number = $urandom_range(0, 99999);
    endcase
    // mostly inside the screen, some off the edges
    c.pos_x      = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLUMNS - 1))
                                                : 7'($urandom_range(COLUMNS, 127));
    c.pos_y      = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, PAGES * 8 - 1))
                                                : 6'($urandom_range(PAGES * 8, 63));
    c.page_index = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, PAGES - 1))
                                                : 3'($urandom_range(PAGES, 7));
    c.data_byte  = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7)       c.run_count = 7'($urandom_range(0, 8));
    else if (pick < 9)  c.run_count = 7'($urandom_range(0, 127));
    else                c.run_count = 7'($urandom_range(COLUMNS, 127));
    return c;
  endfunction

  task automatic send_command(input fb_cmd_t c, input logic preset, input fb_result_t res);
    preset_q.push_back({preset, res});
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // transaction monitor, checker and watchdog
  always @(posedge clk_i) begin : monitor
    fb_cmd_t    cmd_word;
    fb_result_t got;
    fb_result_t want;
    preset_t    pre;
    logic       in_fire;
    logic       out_fire;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    // output first: a result leaving now cannot belong to a command entering now
    if (out_fire) begin
      got = m_axis_tdata;
      result_count++;
      if (got.range_error) range_err_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result next_x=%0d read=%h err=%0b", $time,
                 got.next_x, got.read_data, got.range_error);
      end else begin
        want = pending_results.pop_front();
        if (got.next_x != want.next_x || got.read_data != want.read_data ||
            got.range_error != want.range_error) begin
          mismatch_count++;
          $display("%0t: result %0d want x=%0d rd=%h err=%0b, got x=%0d rd=%h err=%0b",
                   $time, result_count, want.next_x, want.read_data, want.range_error,
                   got.next_x, got.read_data, got.range_error);
        end
      end
    end
    if (in_fire) begin
      cmd_word = fb_cmd_t'(s_axis_tdata);
      case (cmd_word.cmd)
        CMD_DRAW:  draw_count++;
        CMD_OR:    or_count++;
        CMD_CLEAR: clear_count++;
        default:   read_count++;
      endcase
      want = predict_result(cmd_word);
      pre  = preset_q.pop_front();
      pending_results.push_back(pre.preset ? pre.res : want);
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    fb_cmd_t    c;
    fb_result_t r;
    int         i, ph;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    result_count    = 0;
    draw_count      = 0;
    or_count        = 0;
    clear_count     = 0;
    read_count      = 0;
    range_err_count = 0;
    for (i = 0; i < STORE_BYTES; i++) frame_image[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      c            = '0;
      c.cmd        = DIRECTED[i].cmd;
      c.number     = DIRECTED[i].number;
      c.pos_x      = DIRECTED[i].pos_x;
      c.pos_y      = DIRECTED[i].pos_y;
      c.page_index = DIRECTED[i].page_index;
      c.data_byte  = DIRECTED[i].data_byte;
      c.run_count  = DIRECTED[i].run_count;
      r            = '0;
      r.next_x      = DIRECTED[i].exp_next_x;
      r.read_data   = DIRECTED[i].exp_read;
      r.range_error = DIRECTED[i].exp_err;
      send_command(c, DIRECTED[i].preset, r);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct   = SRC_IDLE_PCT[ph];
      sink_stall_pct = SINK_STALL_PCT[ph];
      repeat (ITEMS_PER_PHASE) send_command(random_command(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("ran %0d commands: %0d draws, %0d byte ORs, %0d clears, %0d reads",
             draw_count + or_count + clear_count + read_count, draw_count, or_count,
             clear_count, read_count);
    $display("%0d results checked, %0d with range errors, over four idle/stall mixes",
             result_count, range_err_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fbnr_pkg.sv
rtl/fbnr_ctrl.sv
rtl/fbnr_datapath.sv
rtl/framebuffer_number_renderer_unit.sv
tb/framebuffer_number_renderer_unit_tb.sv
